// ----- src/cstd_pkg.sv -----
// Shared types, constants and helpers for the census stereo disparity block.
// No dependencies; compiled first.
package cstd_pkg;

    // Default geometry and window size
    localparam int DEF_MAX_WIDTH     = 64;
    localparam int DEF_MAX_HEIGHT    = 64;
    localparam int DEF_WINDOW_RADIUS = 6;

    // Fixed field widths
    localparam int COORD_W    = 6;
    localparam int HALF_W     = 64;
    localparam int DESC_W     = 2 * HALF_W;
    localparam int NBYTE      = DESC_W / 8;
    localparam int SUM_W      = $clog2(DESC_W + 1);
    localparam int COST_W     = 15;
    localparam int DISP_W     = 6;
    localparam int DIM_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISPARITY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISPARITY = 2'd3;

    // Register reset values
    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH   = 7'd64;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT  = 7'd64;
    localparam logic [DISP_W-1:0] RST_MAX_DISPARITY = 6'd63;
    localparam logic [DISP_W-1:0] RST_MIN_DISPARITY = 6'd0;

    typedef logic [DESC_W-1:0] t_desc;
    typedef logic [COST_W-1:0] t_cost;

    // Sequencer to cost unit
    typedef struct packed {
        logic clear;   // zero the accumulator
        logic valid;   // descriptor pair present this cycle
    } t_cu_ctrl;

    // Cost unit back to sequencer
    typedef struct packed {
        logic  busy;
        t_cost cost;
    } t_cu_stat;

    function automatic logic [3:0] byte_ones(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(b[i]);
        end
        return n;
    endfunction

endpackage

// ----- src/cstd_ifs.sv -----
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on cstd_pkg.
interface cstd_in_if import cstd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [HALF_W-1:0]  left_lo;
    logic [HALF_W-1:0]  left_hi;
    logic [HALF_W-1:0]  right_lo;
    logic [HALF_W-1:0]  right_hi;

    modport source (output valid, mode, row, col, left_lo, left_hi, right_lo, right_hi,
                    input ready);
    modport sink   (input valid, mode, row, col, left_lo, left_hi, right_lo, right_hi,
                    output ready);
endinterface

interface cstd_out_if import cstd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DISP_W-1:0] disparity;
    logic [COST_W-1:0] best_cost;
    logic              valid_res;

    modport source (output valid, disparity, best_cost, valid_res, input ready);
    modport sink   (input valid, disparity, best_cost, valid_res, output ready);
endinterface

interface cstd_cfg_if import cstd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/cstd_cost_unit.sv -----
// Shared Hamming cost unit: xor, popcount tree and window accumulator.
// Depends on cstd_pkg. Three register stages from descriptor pair to sum.
module cstd_cost_unit import cstd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cu_ctrl i_ctrl,
    input  t_desc    i_left,
    input  t_desc    i_right,
    output t_cu_stat o_stat
);

    logic [3:0]       r_ones [NBYTE];
    logic             r_vld1;
    logic [SUM_W-1:0] r_sum;
    logic             r_vld2;
    t_cost            r_acc;

    t_desc            diff;
    logic [4:0]       lvl1 [NBYTE/2];
    logic [5:0]       lvl2 [NBYTE/4];
    logic [6:0]       lvl3 [NBYTE/8];
    logic [SUM_W-1:0] n_sum;

    assign diff = i_left ^ i_right;

    // adder tree over the byte counts
    always_comb begin
        for (int i = 0; i < NBYTE/2; i++) begin
            lvl1[i] = 5'(r_ones[2*i]) + 5'(r_ones[2*i+1]);
        end
        for (int i = 0; i < NBYTE/4; i++) begin
            lvl2[i] = 6'(lvl1[2*i]) + 6'(lvl1[2*i+1]);
        end
        for (int i = 0; i < NBYTE/8; i++) begin
            lvl3[i] = 7'(lvl2[2*i]) + 7'(lvl2[2*i+1]);
        end
        n_sum = SUM_W'(lvl3[0]) + SUM_W'(lvl3[1]);
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < NBYTE; b++) begin
            r_ones[b] <= byte_ones(diff[b*8 +: 8]);
        end
        r_sum <= n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_acc  <= '0;
        end else begin
            r_vld1 <= i_ctrl.valid;
            r_vld2 <= r_vld1;
            if (i_ctrl.clear) begin
                r_acc <= '0;
            end else if (r_vld2) begin
                r_acc <= r_acc + COST_W'(r_sum);
            end
        end
    end

    assign o_stat.busy = r_vld1 | r_vld2;
    assign o_stat.cost = r_acc;

endmodule

// ----- src/census_stereo_disparity_unit.sv -----
// Census stereo disparity unit: two descriptor memories, search sequencer
// and one shared cost unit. Depends on cstd_pkg, cstd_ifs, cstd_cost_unit.
//
// The unit holds a left and a right image of 128-bit census descriptors
// (MAX_WIDTH x MAX_HEIGHT each, one memory per image, contents undefined until
// written). A write item (mode 0) stores one descriptor pair and returns an
// all-zero result. A query item (mode 1) searches shifts from max_disparity
// down to min_disparity, skipping those whose window would leave the image,
// and returns the shift with the strictly smallest 13x13 (for radius 6)
// Hamming cost; ties keep the larger shift. Border pixels and queries with no
// usable shift return valid_res = 0. At the 64-column maximum at most 52 shifts
// fit (pixel in column 6). The search speed is set by the single read port pair
// on the two memories: one left / right descriptor pair enters the cost unit
// per cycle. The input is held off (ready low) while a query runs; a finished
// result waits in the output register while the next item is taken.
module census_stereo_disparity_unit import cstd_pkg::*; #(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int WINDOW_RADIUS = DEF_WINDOW_RADIUS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cstd_in_if.sink   i_in,
    cstd_out_if.source o_out,
    cstd_cfg_if.sink  i_cfg
);

    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW       = $clog2(DEPTH);
    localparam int WIN      = 2 * WINDOW_RADIUS + 1;
    localparam int WCW      = $clog2(WIN);
    localparam int MAX_COST = WIN * WIN * DESC_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;   // pick next shift or finish
    localparam logic [2:0] S_SCAN  = 3'd2;   // one window read pair per cycle
    localparam logic [2:0] S_DRAIN = 3'd3;   // wait for cost pipe, compare
    localparam logic [2:0] S_DONE  = 3'd4;   // hand result to output register

    // descriptor memories
    t_desc mem_l [DEPTH];
    t_desc mem_r [DEPTH];
    t_desc r_rd_l;
    t_desc r_rd_r;
    logic  r_rd_vld;

    // configuration
    logic [DIM_W-1:0]  r_cfg_w;
    logic [DIM_W-1:0]  r_cfg_h;
    logic [DISP_W-1:0] r_cfg_max;
    logic [DISP_W-1:0] r_cfg_min;

    // sequencer
    logic [2:0]         r_state, n_state;
    logic [COORD_W-1:0] r_row, n_row;
    logic [COORD_W-1:0] r_col, n_col;
    logic [DISP_W-1:0]  r_d, n_d;
    logic [WCW-1:0]     r_wx, n_wx;
    logic [WCW-1:0]     r_wy, n_wy;
    logic               r_found, n_found;
    t_cost              r_best, n_best;
    logic [DISP_W-1:0]  r_best_d, n_best_d;

    // output register
    logic              r_out_valid;
    logic [DISP_W-1:0] r_out_disp;
    t_cost             r_out_cost;
    logic              r_out_vres;

    logic        in_xfer;
    logic        we;
    logic        re;
    logic        in_store;
    logic        border;
    logic        skip_d;
    logic        load_out;
    logic [DIM_W-1:0] clamp_w;
    logic [DIM_W-1:0] clamp_h;
    logic [7:0]  win_y;
    logic [7:0]  win_x;
    logic [7:0]  win_xl;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr_l;
    logic [AW-1:0] raddr_r;
    t_desc       wdata_l;
    t_desc       wdata_r;
    t_cu_ctrl    cu_ctrl;
    t_cu_stat    cu_stat;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_in.valid && i_in.ready;

    // geometry above the store size saturates
    assign clamp_w = (32'(r_cfg_w) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : r_cfg_w;
    assign clamp_h = (32'(r_cfg_h) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : r_cfg_h;

    // window must sit fully inside rows and clear the left edge
    assign border = (8'(i_in.row) < 8'(WINDOW_RADIUS))
                 || ((8'(i_in.row) + 8'(WINDOW_RADIUS)) >= 8'(clamp_h))
                 || (8'(i_in.col) < 8'(WINDOW_RADIUS));

    // shifted left window must stay left of the used width
    assign skip_d = (8'(r_col) + 8'(WINDOW_RADIUS) + 8'(r_d)) >= 8'(clamp_w);

    // write port
    assign in_store = (32'(i_in.row) < MAX_HEIGHT) && (32'(i_in.col) < MAX_WIDTH);
    assign we       = in_xfer && (i_in.mode == MODE_WRITE) && in_store;
    assign waddr    = AW'(i_in.row) * AW'(MAX_WIDTH) + AW'(i_in.col);
    assign wdata_l  = {i_in.left_hi, i_in.left_lo};
    assign wdata_r  = {i_in.right_hi, i_in.right_lo};

    // read port: window position for current shift
    assign re      = (r_state == S_SCAN);
    assign win_y   = 8'(r_row) - 8'(WINDOW_RADIUS) + 8'(r_wy);
    assign win_x   = 8'(r_col) - 8'(WINDOW_RADIUS) + 8'(r_wx);
    assign win_xl  = win_x + 8'(r_d);
    assign raddr_r = AW'(win_y) * AW'(MAX_WIDTH) + AW'(win_x);
    assign raddr_l = AW'(win_y) * AW'(MAX_WIDTH) + AW'(win_xl);

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_l[waddr] <= wdata_l;
            mem_r[waddr] <= wdata_r;
        end
        if (re) begin
            r_rd_l <= mem_l[raddr_l];
            r_rd_r <= mem_r[raddr_r];
        end
    end

    cstd_cost_unit u_cost (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cu_ctrl),
        .i_left  (r_rd_l),
        .i_right (r_rd_r),
        .o_stat  (cu_stat)
    );

    assign load_out = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // search sequencer
    always_comb begin
        n_state       = r_state;
        n_row         = r_row;
        n_col         = r_col;
        n_d           = r_d;
        n_wx          = r_wx;
        n_wy          = r_wy;
        n_found       = r_found;
        n_best        = r_best;
        n_best_d      = r_best_d;
        cu_ctrl.clear = 1'b0;
        cu_ctrl.valid = r_rd_vld;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_row   = i_in.row;
                    n_col   = i_in.col;
                    n_d     = r_cfg_max;
                    n_found = 1'b0;
                    if (i_in.mode == MODE_WRITE || border) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DISP;
                    end
                end
            end
            S_DISP: begin
                if (r_d < r_cfg_min) begin
                    n_state = S_DONE;
                end else if (skip_d) begin
                    if (r_d == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_d = r_d - 1'b1;
                    end
                end else begin
                    cu_ctrl.clear = 1'b1;
                    n_wx          = '0;
                    n_wy          = '0;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_wx == WCW'(WIN - 1)) begin
                    n_wx = '0;
                    if (r_wy == WCW'(WIN - 1)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_wy = r_wy + 1'b1;
                    end
                end else begin
                    n_wx = r_wx + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !cu_stat.busy) begin
                    // strict compare: the earlier (larger) shift keeps ties
                    if (!r_found || (cu_stat.cost < r_best)) begin
                        n_found  = 1'b1;
                        n_best   = cu_stat.cost;
                        n_best_d = r_d;
                    end
                    if (r_d == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_d     = r_d - 1'b1;
                        n_state = S_DISP;
                    end
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_wx        <= '0;
            r_wy        <= '0;
            r_out_valid <= 1'b0;
            r_cfg_w     <= RST_IMAGE_WIDTH;
            r_cfg_h     <= RST_IMAGE_HEIGHT;
            r_cfg_max   <= RST_MAX_DISPARITY;
            r_cfg_min   <= RST_MIN_DISPARITY;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= re;
            r_found  <= n_found;
            r_wx     <= n_wx;
            r_wy     <= n_wy;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_IMAGE_WIDTH:   r_cfg_w   <= i_cfg.data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT:  r_cfg_h   <= i_cfg.data[DIM_W-1:0];
                    REG_MAX_DISPARITY: r_cfg_max <= i_cfg.data[DISP_W-1:0];
                    REG_MIN_DISPARITY: r_cfg_min <= i_cfg.data[DISP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_col    <= n_col;
        r_d      <= n_d;
        r_best   <= n_best;
        r_best_d <= n_best_d;
        if (load_out) begin
            r_out_disp <= r_found ? r_best_d : '0;
            r_out_cost <= r_found ? r_best : '0;
            r_out_vres <= r_found;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.disparity = r_out_disp;
    assign o_out.best_cost = r_out_cost;
    assign o_out.valid_res = r_out_vres;

    // a new shift only starts with the cost pipe empty
    a_disp_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP) |-> (!r_rd_vld && !cu_stat.busy))
        else $error("cost pipe busy at shift start");

    // read data only follows a scan cycle
    a_read_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ($past(r_state) == S_SCAN))
        else $error("memory read outside window scan");

    // a result is only posted from the finish state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result posted outside finish state");

    // the winning cost never exceeds the full-window bound
    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (32'(r_best) <= MAX_COST))
        else $error("best cost out of range");

endmodule
